// ===== hdl/imu_offset_calibrator_unit_defines.svh =====
// Assertion macros for the IMU offset calibrator.
// Included by the top level; no other dependencies.
`ifndef IMU_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH
`define IMU_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IOC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ioc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define IOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ioc: next-cycle check failed");

`endif

// ===== hdl/ioc_pkg.sv =====
// Shared types, constants and helpers of the IMU offset calibrator.
// No dependencies.
package ioc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int IDX_W     = 11;
   localparam int LAST_W    = 12;
   localparam int SUM_W     = 27;
   localparam int DIVD_W    = 28;
   localparam int DIVS_W    = 11;
   localparam int ERR_W     = 28;
   localparam int CORR_W    = 28;
   localparam int NUM_AXES  = 6;
   localparam int AXIS_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;
   localparam int DZ_W      = 8;

   localparam logic signed [ERR_W-1:0] ACCEL_ONE_G = ERR_W'(32'sd16384);
   localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_FIRST_GYRO = 3'd3;
   localparam logic [AXIS_W-1:0] AXIS_LAST = 3'd5;
   localparam logic [AXIS_W-1:0] ALL_READY = 3'd6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_DZ     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_DZ      = 2'd2;

   localparam logic [CSR_DAT_W-1:0] SAMPLE_COUNT_RST = 11'd1000;
   localparam logic [DZ_W-1:0]      ACCEL_DZ_RST     = 8'd8;
   localparam logic [DZ_W-1:0]      GYRO_DZ_RST      = 8'd1;

   // Calibration phase
   typedef enum logic [2:0] {
      PH_FIRST = 3'b001,
      PH_LATER = 3'b010,
      PH_DONE  = 3'b100
   } phase_type;

   typedef struct packed {
      logic load_req;
      logic restart;
      logic accum;
      logic advance;
      logic div_start;
      logic div_sel_err;
      logic take_err;
      logic write_first;
      logic count_ready;
      logic write_corr;
      logic axis_inc;
      logic finish;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_restart;
      logic phase_done;
      logic phase_first;
      logic pass_end;
      logic div_busy;
      logic div_done;
      logic in_deadzone;
      logic axis_last;
   } ctrl_stat_type;

   // Clamp to int16
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [CORR_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > CORR_W'(32'sd32767)) r = 16'sh7fff;
      else if (v < CORR_W'(-32'sd32768)) r = 16'sh8000;
      else r = v[SAMPLE_W-1:0];
      return r;
   endfunction

endpackage

// ===== hdl/ioc_intf.sv =====
// Channel interfaces of the IMU offset calibrator: request, response, CSR write.
// Depends on ioc_pkg.
interface ioc_req_if import ioc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [SAMPLE_W-1:0] accel_x;
   logic signed [SAMPLE_W-1:0] accel_y;
   logic signed [SAMPLE_W-1:0] accel_z;
   logic signed [SAMPLE_W-1:0] gyro_x;
   logic signed [SAMPLE_W-1:0] gyro_y;
   logic signed [SAMPLE_W-1:0] gyro_z;
   modport source (output valid, req_type, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, input ready);
   modport sink   (input valid, req_type, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface ioc_rsp_if import ioc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] offset_accel_x;
   logic signed [SAMPLE_W-1:0] offset_accel_y;
   logic signed [SAMPLE_W-1:0] offset_accel_z;
   logic signed [SAMPLE_W-1:0] offset_gyro_x;
   logic signed [SAMPLE_W-1:0] offset_gyro_y;
   logic signed [SAMPLE_W-1:0] offset_gyro_z;
   logic                       converged;
   modport source (output valid, offset_accel_x, offset_accel_y, offset_accel_z,
                   offset_gyro_x, offset_gyro_y, offset_gyro_z, converged, input ready);
   modport sink   (input valid, offset_accel_x, offset_accel_y, offset_accel_z,
                   offset_gyro_x, offset_gyro_y, offset_gyro_z, converged, output ready);
endinterface

interface ioc_csr_if import ioc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ioc_divider.sv =====
// Shared restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one bit per cycle. Depends on ioc_pkg.
module ioc_divider import ioc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0]        divisor,
   output logic                     busy,
   output logic                     done,
   output logic signed [DIVD_W-1:0] quotient
);
   localparam int MAG_W = DIVD_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic              busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [DIVS_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIVS_W:0]   trial;
   logic [DIVD_W-1:0] abs_dvd;

   // Load operands or shift one quotient bit
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      count_in = count_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      abs_dvd  = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
      trial    = {rem_ff, mag_ff[MAG_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         neg_in   = dividend[DIVD_W-1];
         count_in = CNT_W'(MAG_W);
         mag_in   = abs_dvd[MAG_W-1:0];
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVS_W'(trial - {1'b0, dsr_ff});
            mag_in = {mag_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      count_ff <= count_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule

// ===== hdl/ioc_datapath.sv =====
// Datapath: sample latch, per-axis sums, offsets, config registers, divider
// and response register. Depends on ioc_pkg and ioc_divider.
module ioc_datapath import ioc_pkg::*; #(
   parameter int MAX_SAMPLE_COUNT = 1024,
   parameter int DISCARD_COUNT    = 101
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output ctrl_stat_type              stat,
   input  logic                       req_type,
   input  logic signed [SAMPLE_W-1:0] accel_x,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   input  logic signed [SAMPLE_W-1:0] accel_z,
   input  logic signed [SAMPLE_W-1:0] gyro_x,
   input  logic signed [SAMPLE_W-1:0] gyro_y,
   input  logic signed [SAMPLE_W-1:0] gyro_z,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data,
   output logic signed [SAMPLE_W-1:0] rsp_offset [NUM_AXES],
   output logic                       rsp_converged
);
   logic                       restart_ff;
   logic signed [SAMPLE_W-1:0] sample_ff [NUM_AXES];
   logic signed [SUM_W-1:0]    sum_ff [NUM_AXES];
   logic signed [SAMPLE_W-1:0] offset_ff [NUM_AXES];
   logic signed [SAMPLE_W-1:0] rsp_off_ff [NUM_AXES];
   logic                       rsp_conv_ff, conv_ff;
   logic [IDX_W-1:0]           index_ff;
   phase_type                  phase_ff;
   logic [AXIS_W-1:0]          axis_ff, ready_cnt_ff;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic [CSR_DAT_W-1:0]       sample_count_ff;
   logic [DZ_W-1:0]            accel_dz_ff, gyro_dz_ff;

   logic [CSR_DAT_W-1:0]       eff_count;
   logic [LAST_W-1:0]          last_idx;
   logic                       in_discard, is_accel;
   logic signed [DIVD_W-1:0]   div_dvd, quot;
   logic [DIVS_W-1:0]          div_dsr;
   logic                       div_busy, div_done;
   logic [ERR_W-1:0]           err_abs;
   logic [DZ_W-1:0]            dz;
   logic signed [ERR_W-1:0]    mean, err_adj;
   logic signed [CORR_W-1:0]   first_q, corr_sum;

   // Effective count and pass end
   always_comb begin
      if (sample_count_ff == '0) eff_count = CSR_DAT_W'(1);
      else if (32'(sample_count_ff) > MAX_SAMPLE_COUNT) eff_count = CSR_DAT_W'(MAX_SAMPLE_COUNT);
      else eff_count = sample_count_ff;
      last_idx   = LAST_W'(DISCARD_COUNT) + LAST_W'(eff_count) - LAST_W'(1);
      in_discard = LAST_W'(index_ff) < LAST_W'(DISCARD_COUNT);
   end

   // Per-axis arithmetic
   always_comb begin
      is_accel = axis_ff < AXIS_FIRST_GYRO;
      mean     = quot[ERR_W-1:0];
      err_in   = (axis_ff == AXIS_ACCEL_Z) ? ACCEL_ONE_G - mean : -mean;
      err_abs  = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      dz       = is_accel ? accel_dz_ff : gyro_dz_ff;
      err_adj  = err_ff;
      if (err_ff[ERR_W-1]) err_adj = err_ff + (is_accel ? ERR_W'(32'sd7) : ERR_W'(32'sd3));
      first_q  = is_accel ? CORR_W'(err_adj >>> 3) : CORR_W'(err_adj >>> 2);
      corr_sum = CORR_W'(offset_ff[axis_ff]) + quot[CORR_W-1:0];
      if (cmd.div_sel_err) begin
         div_dvd = DIVD_W'(err_ff);
         if (is_accel) div_dsr = (accel_dz_ff == '0) ? DIVS_W'(1) : DIVS_W'(accel_dz_ff);
         else div_dsr = DIVS_W'(gyro_dz_ff) + DIVS_W'(1);
      end else begin
         div_dvd = DIVD_W'(sum_ff[axis_ff]);
         div_dsr = eff_count;
      end
   end

   ioc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RST;
         accel_dz_ff     <= ACCEL_DZ_RST;
         gyro_dz_ff      <= GYRO_DZ_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_data;
            CSR_ACCEL_DZ:     accel_dz_ff     <= csr_data[DZ_W-1:0];
            CSR_GYRO_DZ:      gyro_dz_ff      <= csr_data[DZ_W-1:0];
            default: ;
         endcase
      end
   end

   // Latch the request and the axis error
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         restart_ff   <= req_type;
         sample_ff[0] <= accel_x;
         sample_ff[1] <= accel_y;
         sample_ff[2] <= accel_z;
         sample_ff[3] <= gyro_x;
         sample_ff[4] <= gyro_y;
         sample_ff[5] <= gyro_z;
      end
      if (cmd.take_err) err_ff <= err_in;
   end

   // Calibration state
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         index_ff     <= '0;
         phase_ff     <= PH_FIRST;
         axis_ff      <= '0;
         ready_cnt_ff <= '0;
         conv_ff      <= 1'b0;
         for (int k = 0; k < NUM_AXES; k++) begin
            sum_ff[k]    <= '0;
            offset_ff[k] <= '0;
         end
      end else begin
         if (cmd.accum && !in_discard) begin
            for (int k = 0; k < NUM_AXES; k++) sum_ff[k] <= sum_ff[k] + SUM_W'(sample_ff[k]);
         end
         if (cmd.advance) index_ff <= index_ff + 1'b1;
         if (cmd.write_first) offset_ff[axis_ff] <= sat16(first_q);
         if (cmd.write_corr) offset_ff[axis_ff] <= sat16(corr_sum);
         if (cmd.count_ready) ready_cnt_ff <= ready_cnt_ff + 1'b1;
         if (cmd.axis_inc) axis_ff <= axis_ff + 1'b1;
         if (cmd.finish) begin
            index_ff     <= '0;
            axis_ff      <= '0;
            ready_cnt_ff <= '0;
            for (int k = 0; k < NUM_AXES; k++) sum_ff[k] <= '0;
            conv_ff <= (phase_ff != PH_FIRST) && (ready_cnt_ff == ALL_READY);
            if (phase_ff == PH_FIRST) phase_ff <= PH_LATER;
            else if (ready_cnt_ff == ALL_READY) phase_ff <= PH_DONE;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_off_ff  <= offset_ff;
         rsp_conv_ff <= conv_ff;
      end
   end

   assign rsp_offset    = rsp_off_ff;
   assign rsp_converged = rsp_conv_ff;

   always_comb begin
      stat.is_restart  = restart_ff;
      stat.phase_done  = phase_ff == PH_DONE;
      stat.phase_first = phase_ff == PH_FIRST;
      stat.pass_end    = LAST_W'(index_ff) >= last_idx;
      stat.div_busy    = div_busy;
      stat.div_done    = div_done;
      stat.in_deadzone = err_abs <= ERR_W'(dz);
      stat.axis_last   = axis_ff == AXIS_LAST;
   end
endmodule

// ===== hdl/ioc_ctrl.sv =====
// Controller: sequences acceptance, accumulation, the per-axis division
// steps and the response handshake. Depends on ioc_pkg.
module ioc_ctrl import ioc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ACCUM  = 8'b0000_0010,
      S_START  = 8'b0000_0100,
      S_MEAN   = 8'b0000_1000,
      S_CHECK  = 8'b0001_0000,
      S_CORR   = 8'b0010_0000,
      S_FINISH = 8'b0100_0000,
      S_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (stat.is_restart) begin
               cmd.restart = 1'b1;
               state_in    = S_EMIT;
            end else if (stat.phase_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.accum = 1'b1;
               if (stat.pass_end) state_in = S_START;
               else begin
                  cmd.advance = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_MEAN;
         end
         S_MEAN: begin
            if (stat.div_done) begin
               cmd.take_err = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.phase_first || stat.in_deadzone) begin
               cmd.write_first = stat.phase_first;
               cmd.count_ready = !stat.phase_first;
               cmd.axis_inc    = !stat.axis_last;
               state_in        = stat.axis_last ? S_FINISH : S_START;
            end else begin
               cmd.div_start   = 1'b1;
               cmd.div_sel_err = 1'b1;
               state_in        = S_CORR;
            end
         end
         S_CORR: begin
            cmd.div_sel_err = 1'b1;
            if (stat.div_done) begin
               cmd.write_corr = 1'b1;
               cmd.axis_inc   = !stat.axis_last;
               state_in       = stat.axis_last ? S_FINISH : S_START;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== hdl/imu_offset_calibrator_unit.sv =====
// IMU offset calibrator, top level.
// Depends on ioc_pkg, the channel interfaces, ioc_ctrl, ioc_datapath and the defines header.
//
// Usage: req_chan carries six-axis samples (req_type 0) or a restart (req_type 1);
// rsp_chan returns the six offsets and the converged flag; csr_chan writes
// sample_count (0), accel_deadzone (1) and gyro_deadzone (2) and is always ready.
// One transaction is worked on at a time. A sample inside a pass goes through
// S_ACCUM and back to S_IDLE, where req_chan.ready rises again. A restart goes
// from S_ACCUM to S_EMIT, which registers its response once the output slot is
// free. A sample that ends a pass runs six mean divisions and up to six
// correction divisions through one shared bit-serial divider before its
// response is registered; there are six corrections when every axis needs one.
// The response sits in an output register: while it waits for rsp_chan.ready,
// new samples are still accepted; only the next response waits for the slot.
// Reset (synchronous) restores the register defaults, zero offsets and
// first-pass state, and leaves no response pending.
`include "imu_offset_calibrator_unit_defines.svh"
module imu_offset_calibrator_unit import ioc_pkg::*; #(
   parameter int MAX_SAMPLE_COUNT = 1024,
   parameter int DISCARD_COUNT    = 101
) (
   input logic         clock,
   input logic         reset,
   ioc_req_if.sink     req_chan,
   ioc_rsp_if.source   rsp_chan,
   ioc_csr_if.sink     csr_chan
);
   ctrl_cmd_type               cmd;
   ctrl_stat_type              stat;
   logic signed [SAMPLE_W-1:0] rsp_offset [NUM_AXES];
   logic                       rsp_converged;

   ioc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ioc_datapath #(
      .MAX_SAMPLE_COUNT (MAX_SAMPLE_COUNT),
      .DISCARD_COUNT    (DISCARD_COUNT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_chan.req_type),
      .accel_x       (req_chan.accel_x),
      .accel_y       (req_chan.accel_y),
      .accel_z       (req_chan.accel_z),
      .gyro_x        (req_chan.gyro_x),
      .gyro_y        (req_chan.gyro_y),
      .gyro_z        (req_chan.gyro_z),
      .csr_write     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .rsp_offset    (rsp_offset),
      .rsp_converged (rsp_converged)
   );

   // Drive the response payload and the CSR ready
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.offset_accel_x = rsp_offset[0];
   assign rsp_chan.offset_accel_y = rsp_offset[1];
   assign rsp_chan.offset_accel_z = rsp_offset[2];
   assign rsp_chan.offset_gyro_x  = rsp_offset[3];
   assign rsp_chan.offset_gyro_y  = rsp_offset[4];
   assign rsp_chan.offset_gyro_z  = rsp_offset[5];
   assign rsp_chan.converged      = rsp_converged;

   // One transaction in flight at a time
   `IOC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // Divider runs only for an accepted transaction
   `IOC_ASSERT_IMPLIES(a_div_owned, clock, reset, stat.div_busy, !req_chan.ready)
   // Restart flag follows the accepted request
   `IOC_ASSERT_NEXT(a_restart_latched, clock, reset, req_chan.valid && req_chan.ready && req_chan.req_type, stat.is_restart)
endmodule

// ===== tb/imu_offset_calibrator_unit_test.sv =====
// Self-checking testbench for the IMU offset calibrator top level.
// Depends on ioc_pkg, the ioc channel interfaces and imu_offset_calibrator_unit.
module imu_offset_calibrator_unit_test;
   import ioc_pkg::*;

   localparam int DISCARD    = 101;
   localparam int MAX_COUNT  = 1024;
   localparam int SETTLE     = 400;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_LEN   = 3000;

   typedef enum int {STY_QUIET, STY_RANDOM, STY_EXTREME, STY_BIAS} sample_style_t;

   typedef struct packed {
      logic             rtype;
      logic [5:0][15:0] axis;
   } imu_item_t;

   typedef struct packed {
      logic [5:0][15:0] off;
      logic             conv;
   } offset_rsp_t;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] data;
   } csr_write_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ioc_req_if req_bus ();
   ioc_rsp_if rsp_bus ();
   ioc_csr_if csr_bus ();

   imu_offset_calibrator_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of configuration and calibration state
   int unsigned  cfg_count;
   int unsigned  cfg_accel_dz;
   int unsigned  cfg_gyro_dz;
   logic [10:0]  pass_idx;
   longint       axis_acc [6];
   longint       axis_off [6];
   phase_type    cal_phase;

   imu_item_t    pending_items[$];
   csr_write_t   pending_csr[$];
   offset_rsp_t  expected_offsets[$];
   imu_item_t    cur_item;

   int           error_count;
   int           items_taken;
   int           results_seen;
   int           idle_mode;
   bit           stall_arm;
   bit           stall_done;
   int           hold_left;
   int           quiet_cycles;
   longint       phase_bias [6];

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int unsigned active_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > MAX_COUNT) return MAX_COUNT;
      return cfg_count;
   endfunction

   function automatic void clear_sums();
      pass_idx = '0;
      for (int k = 0; k < 6; k++) axis_acc[k] = 0;
   endfunction

   // Close a pass: form means, update offsets, report convergence
   function automatic bit close_pass();
      longint cnt;
      longint mean;
      longint err;
      longint dz;
      longint dv;
      int     in_zone;
      cnt = active_count();
      in_zone = 0;
      for (int k = 0; k < 6; k++) begin
         mean = axis_acc[k] / cnt;
         err = (k == 2) ? 16384 - mean : -mean;
         if (cal_phase == PH_FIRST) begin
            axis_off[k] = clamp16(err / ((k < 3) ? 8 : 4));
         end else begin
            dz = (k < 3) ? cfg_accel_dz : cfg_gyro_dz;
            dv = (k < 3) ? ((cfg_accel_dz == 0) ? 1 : cfg_accel_dz) : cfg_gyro_dz + 1;
            if (((err < 0) ? -err : err) <= dz) in_zone++;
            else axis_off[k] = clamp16(axis_off[k] + err / dv);
         end
      end
      if (cal_phase == PH_FIRST) begin
         cal_phase = PH_LATER;
         return 1'b0;
      end
      if (in_zone == 6) begin
         cal_phase = PH_DONE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the calibration state by one transaction
   function automatic bit predict_offsets(input imu_item_t it, output offset_rsp_t r);
      bit conv;
      r = '0;
      if (it.rtype) begin
         clear_sums();
         for (int k = 0; k < 6; k++) axis_off[k] = 0;
         cal_phase = PH_FIRST;
         return 1'b1;
      end
      if (cal_phase == PH_DONE) return 1'b0;
      if (pass_idx >= DISCARD)
         for (int k = 0; k < 6; k++) axis_acc[k] += longint'($signed(it.axis[k]));
      if (pass_idx >= DISCARD + active_count() - 1) begin
         conv = close_pass();
         clear_sums();
         for (int k = 0; k < 6; k++) r.off[k] = axis_off[k][15:0];
         r.conv = conv;
         return 1'b1;
      end
      pass_idx = pass_idx + 11'd1;
      return 1'b0;
   endfunction

   function automatic bit sender_idles();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_mode == 0) return roll < 10;
      if (idle_mode == 1) return roll < 69;
      return 1'b0;
   endfunction

   function automatic bit receiver_idles();
      int roll;
      roll = $urandom_range(0, 99);
      if (idle_mode == 0) return roll < 69;
      if (idle_mode == 1) return roll < 10;
      return 1'b0;
   endfunction

   // Drive request and CSR channels from their queues
   always @(posedge clock) begin
      logic        nv;
      logic        cv;
      offset_rsp_t r;
      nv = req_bus.valid;
      cv = csr_bus.valid;
      if (reset) begin
         nv = 1'b0;
         cv = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (predict_offsets(cur_item, r)) expected_offsets.push_back(r);
            items_taken++;
            // Swap idling roles as the run advances
            if (items_taken >= 800) idle_mode = 2;
            else if (items_taken >= 400) idle_mode = 1;
            nv = 1'b0;
         end
         if (!nv && pending_items.size() > 0 && !sender_idles()) begin
            cur_item = pending_items.pop_front();
            req_bus.req_type <= cur_item.rtype;
            req_bus.accel_x  <= cur_item.axis[0];
            req_bus.accel_y  <= cur_item.axis[1];
            req_bus.accel_z  <= cur_item.axis[2];
            req_bus.gyro_x   <= cur_item.axis[3];
            req_bus.gyro_y   <= cur_item.axis[4];
            req_bus.gyro_z   <= cur_item.axis[5];
            nv = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_SAMPLE_COUNT: cfg_count = csr_bus.data;
               CSR_ACCEL_DZ:     cfg_accel_dz = csr_bus.data[7:0];
               CSR_GYRO_DZ:      cfg_gyro_dz = csr_bus.data[7:0];
               default: ;
            endcase
            cv = 1'b0;
         end
         if (!cv && pending_csr.size() > 0) begin
            csr_write_t w;
            w = pending_csr.pop_front();
            csr_bus.index <= w.idx;
            csr_bus.data  <= w.data;
            cv = 1'b1;
         end
      end
      req_bus.valid <= nv;
      csr_bus.valid <= cv;
   end

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
         error_count++;
      end
   endtask

   // Compare responses and drive ready, with one long hold-off
   always @(posedge clock) begin
      logic        rdy;
      offset_rsp_t e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_offsets.size() == 0) begin
            $error("unexpected response transaction");
            error_count++;
         end else begin
            e = expected_offsets.pop_front();
            check_field("offset_accel_x", e.off[0], rsp_bus.offset_accel_x);
            check_field("offset_accel_y", e.off[1], rsp_bus.offset_accel_y);
            check_field("offset_accel_z", e.off[2], rsp_bus.offset_accel_z);
            check_field("offset_gyro_x", e.off[3], rsp_bus.offset_gyro_x);
            check_field("offset_gyro_y", e.off[4], rsp_bus.offset_gyro_y);
            check_field("offset_gyro_z", e.off[5], rsp_bus.offset_gyro_z);
            check_field("converged", {15'd0, e.conv}, {15'd0, rsp_bus.converged});
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rdy = 1'b0;
      end else if (stall_arm && !stall_done) begin
         hold_left <= HOLD_LEN;
         stall_done <= 1'b1;
         rdy = 1'b0;
      end else begin
         rdy = !receiver_idles();
      end
      rsp_bus.ready <= reset ? 1'b0 : rdy;
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic imu_item_t make_sample(input sample_style_t sty, input int noise);
      imu_item_t it;
      longint    v;
      it.rtype = 1'b0;
      for (int k = 0; k < 6; k++) begin
         case (sty)
            STY_QUIET:   v = ((k == 2) ? 16384 : 0) + $urandom_range(0, 2 * noise) - noise;
            STY_RANDOM:  v = $urandom_range(0, 65535) - 32768;
            STY_EXTREME: v = $urandom_range(0, 1) ? 32767 : -32768;
            default:     v = clamp16(phase_bias[k] + $urandom_range(0, 2 * noise) - noise);
         endcase
         it.axis[k] = v[15:0];
      end
      return it;
   endfunction

   task automatic push_restart();
      imu_item_t it;
      it = '0;
      it.rtype = 1'b1;
      for (int k = 0; k < 6; k++) it.axis[k] = $urandom_range(0, 65535);
      pending_items.push_back(it);
   endtask

   // Hold until all queued transactions are taken and every response is back
   task automatic settle();
      while (pending_items.size() != 0 || req_bus.valid ||
             pending_csr.size() != 0 || csr_bus.valid) @(posedge clock);
      while (expected_offsets.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_config(input int cnt, input int adz, input int gdz);
      pending_csr.push_back({CSR_SAMPLE_COUNT, CSR_DAT_W'(cnt)});
      pending_csr.push_back({CSR_ACCEL_DZ, CSR_DAT_W'(adz)});
      pending_csr.push_back({CSR_GYRO_DZ, CSR_DAT_W'(gdz)});
   endtask

   // One setting: restart, then whole passes with optional noise restarts
   task automatic run_phase(input int cnt, input int adz, input int gdz,
                            input sample_style_t sty, input int noise,
                            input int passes, input int restart_pct);
      int per_pass;
      settle();
      write_config(cnt, adz, gdz);
      settle();
      per_pass = DISCARD + active_count();
      for (int k = 0; k < 6; k++)
         phase_bias[k] = $urandom_range(0, 8000) - 4000 + ((k == 2) ? 16384 : 0);
      push_restart();
      for (int p = 0; p < passes; p++)
         for (int s = 0; s < per_pass; s++) begin
            if ($urandom_range(0, 999) < restart_pct) push_restart();
            else pending_items.push_back(make_sample(sty, noise));
         end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      req_bus.gyro_x = '0;
      req_bus.gyro_y = '0;
      req_bus.gyro_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      cfg_count = SAMPLE_COUNT_RST;
      cfg_accel_dz = ACCEL_DZ_RST;
      cfg_gyro_dz = GYRO_DZ_RST;
      clear_sums();
      for (int k = 0; k < 6; k++) axis_off[k] = 0;
      cal_phase = PH_FIRST;
      error_count = 0;
      items_taken = 0;
      results_seen = 0;
      idle_mode = 0;
      stall_arm = 1'b0;
      stall_done = 1'b0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a restart straight after reset, zero count and deadzones, extremes
      push_restart();
      run_phase(0, 0, 0, STY_EXTREME, 0, 2, 0);
      // Quiet samples converge; later samples are ignored
      run_phase(1, 255, 255, STY_QUIET, 0, 2, 0);
      for (int s = 0; s < 20; s++) pending_items.push_back(make_sample(STY_QUIET, 0));

      // Shorten the count in the middle of a pass
      run_phase(50, 4, 2, STY_BIAS, 50, 0, 0);
      for (int s = 0; s < DISCARD + 20; s++) pending_items.push_back(make_sample(STY_BIAS, 50));
      settle();
      pending_csr.push_back({CSR_SAMPLE_COUNT, CSR_DAT_W'(10)});
      settle();
      for (int s = 0; s < 3 * (DISCARD + 10); s++)
         pending_items.push_back(make_sample(STY_BIAS, 50));

      // Pile up restarts behind a long receiver hold-off
      settle();
      stall_arm = 1'b1;
      for (int s = 0; s < 12; s++) push_restart();

      // Random settings, mostly well-formed passes with small counts
      while (items_taken < 1200) begin
         sample_style_t sty;
         int            pick;
         pick = $urandom_range(0, 9);
         sty = (pick < 4) ? STY_QUIET : (pick < 7) ? STY_BIAS :
               (pick < 9) ? STY_RANDOM : STY_EXTREME;
         run_phase($urandom_range(1, 8),
                   $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 20),
                   $urandom_range(0, 5) == 0 ? 255 : $urandom_range(0, 6),
                   sty, $urandom_range(0, 2) == 0 ? 300 : $urandom_range(0, 3),
                   $urandom_range(1, 5), $urandom_range(0, 2) == 0 ? 5 : 0);
      end

      settle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ioc_pkg.sv
hdl/ioc_intf.sv
hdl/ioc_divider.sv
hdl/ioc_datapath.sv
hdl/ioc_ctrl.sv
hdl/imu_offset_calibrator_unit.sv
tb/imu_offset_calibrator_unit_test.sv
